### hdl/csg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csg_pkg;

    // Command and span field widths
    localparam int COORD_W  = 11;
    localparam int RADIUS_W = 5;
    localparam int COLOR_W  = 16;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 9;
    localparam int DY_W     = RADIUS_W + 1;

    // Stream payload widths, rounded up to whole bytes
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // r*r - dy*dy never exceeds 31*31, so ten bits carry the root's operand
    localparam int SQ_W      = 10;
    localparam int DIV_CNT_W = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_TEST,
        ST_DIV,
        ST_EMIT
    } csg_state_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] dividend;
        logic [SQ_W-1:0] divisor;
    } csg_div_req_t;

    typedef struct packed {
        logic            done;
        logic [SQ_W-1:0] quotient;
    } csg_div_rsp_t;

    typedef struct packed {
        logic signed [ROW_W-1:0] row;
        logic [COL_W-1:0]        x_start;
        logic [COL_W-1:0]        x_end;
        logic                    visible;
    } csg_span_t;

endpackage

`default_nettype wire

### hdl/csg_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module csg_div
    import csg_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire csg_div_req_t req,
    output csg_div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]      rem_reg, rem_next;
    logic [SQ_W-1:0]      quo_reg, quo_next;
    logic [SQ_W-1:0]      dvs_reg, dvs_next;

    logic [SQ_W:0]        rem_sh;
    logic                 ge;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[SQ_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = ge ? SQ_W'(rem_sh - {1'b0, dvs_reg}) : SQ_W'(rem_sh);
            quo_next = {quo_reg[SQ_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(SQ_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### hdl/csg_clip.sv
`timescale 1ns / 1ps
`default_nettype none

// Places one row of the disc on the screen and clips it.
module csg_clip
    import csg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  wire logic signed [COORD_W-1:0] center_x,
    input  wire logic signed [COORD_W-1:0] center_y,
    input  wire logic signed [DY_W-1:0]    dy,
    input  wire logic [RADIUS_W-1:0]       half_w,
    output csg_span_t                      span
);

    localparam logic signed [ROW_W:0] WIDTH_S  = (ROW_W + 1)'(SCREEN_WIDTH);
    localparam logic signed [ROW_W:0] HEIGHT_S = (ROW_W + 1)'(SCREEN_HEIGHT);
    localparam logic signed [ROW_W:0] RIGHT_MAX = (ROW_W + 1)'(SCREEN_WIDTH - 1);

    logic signed [ROW_W:0] row_s;
    logic signed [ROW_W:0] left_s;
    logic signed [ROW_W:0] right_s;
    logic signed [ROW_W:0] left_c;
    logic signed [ROW_W:0] right_c;
    logic                  vis;

    always_comb begin
        row_s   = (ROW_W + 1)'(center_y) + (ROW_W + 1)'(dy);
        left_s  = (ROW_W + 1)'(center_x) - $signed({{(ROW_W + 1 - RADIUS_W){1'b0}}, half_w});
        right_s = (ROW_W + 1)'(center_x) + $signed({{(ROW_W + 1 - RADIUS_W){1'b0}}, half_w});
        vis     = (row_s >= 0) && (row_s < HEIGHT_S) && (right_s >= 0) && (left_s < WIDTH_S);
        left_c  = (left_s < 0) ? '0 : left_s;
        right_c = (right_s > RIGHT_MAX) ? RIGHT_MAX : right_s;

        span.row     = row_s[ROW_W-1:0];
        span.x_start = vis ? left_c[COL_W-1:0] : '0;
        span.x_end   = vis ? right_c[COL_W-1:0] : '0;
        span.visible = vis;
    end

endmodule

`default_nettype wire

### hdl/filled_circle_span_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Filled circle span generator. Each request on the s_ channel is one circle
// (center, radius, color, and tuser high for the top half only); the block
// returns one span per row from center_y - radius downward to center_y + radius
// (or center_y in top-half mode), tlast on the final one, tuser high when the
// span has pixels on screen. Radius is saturated to MAX_RADIUS. The half width
// of each row is an integer square root found by repeated averaging, and every
// step uses one shared restoring divider, so a row takes longer the more
// averaging steps its root needs. s_tready is high only between requests;
// one finished span can wait in the output register while the next is
// computed.
module filled_circle_span_generator
    import csg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_RADIUS    = 31
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // center_x[10:0], center_y[21:11], radius[26:22], fill_color[42:27]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // func
    input  wire logic                s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // span_row[11:0], x_start[20:12], x_end[29:21], span_color[45:30]
    output logic [M_DATA_W-1:0]      m_tdata,
    // visible
    output logic                     m_tuser,
    output logic                     m_tlast
);

    localparam logic [RADIUS_W-1:0] R_MAX = RADIUS_W'(MAX_RADIUS);

    csg_state_t                 state_reg, state_next;
    logic signed [COORD_W-1:0]  cx_reg, cx_next;
    logic signed [COORD_W-1:0]  cy_reg, cy_next;
    logic [COLOR_W-1:0]         color_reg, color_next;
    logic                       top_reg, top_next;
    logic [RADIUS_W-1:0]        r_reg, r_next;
    logic [SQ_W-1:0]            r2_reg, r2_next;
    logic signed [DY_W-1:0]     dy_reg, dy_next;
    logic [SQ_W-1:0]            n_reg, n_next;
    logic [SQ_W-1:0]            x_reg, x_next;
    logic [SQ_W-1:0]            y_reg, y_next;

    logic                       m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]        m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;
    logic                       m_last_reg, m_last_next;

    logic [RADIUS_W-1:0]        r_in;
    logic [RADIUS_W-1:0]        r_sat;
    logic [RADIUS_W-1:0]        dy_abs;
    logic signed [DY_W-1:0]     dy_end;
    logic [SQ_W:0]              xy_sum;
    logic                       row_last;
    logic                       out_free;

    csg_div_req_t               div_req;
    csg_div_rsp_t               div_rsp;
    csg_span_t                  span;

    csg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    csg_clip #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_clip (
        .center_x (cx_reg),
        .center_y (cy_reg),
        .dy       (dy_reg),
        .half_w   (x_reg[RADIUS_W-1:0]),
        .span     (span)
    );

    always_comb begin
        r_in     = s_tdata[2*COORD_W +: RADIUS_W];
        r_sat    = (r_in > R_MAX) ? R_MAX : r_in;
        dy_abs   = dy_reg[DY_W-1] ? RADIUS_W'(-dy_reg) : RADIUS_W'(dy_reg);
        dy_end   = top_reg ? '0 : $signed({1'b0, r_reg});
        row_last = dy_reg == dy_end;
        xy_sum   = {1'b0, x_reg} + {1'b0, y_reg};
        out_free = !m_valid_reg || m_tready;

        state_next   = state_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        color_next   = color_reg;
        top_next     = top_reg;
        r_next       = r_reg;
        r2_next      = r2_reg;
        dy_next      = dy_reg;
        n_next       = n_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;

        div_req.start    = 1'b0;
        div_req.dividend = n_reg;
        div_req.divisor  = xy_sum[SQ_W:1];

        s_tready = state_reg == ST_IDLE;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cx_next    = s_tdata[0 +: COORD_W];
                    cy_next    = s_tdata[COORD_W +: COORD_W];
                    color_next = s_tdata[2*COORD_W + RADIUS_W +: COLOR_W];
                    top_next   = s_tuser;
                    r_next     = r_sat;
                    r2_next    = SQ_W'(r_sat) * SQ_W'(r_sat);
                    dy_next    = -$signed({1'b0, r_sat});
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                n_next     = r2_reg - SQ_W'(dy_abs) * SQ_W'(dy_abs);
                x_next     = r2_reg - SQ_W'(dy_abs) * SQ_W'(dy_abs);
                y_next     = SQ_W'(1);
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (x_reg > y_reg) begin
                    x_next        = xy_sum[SQ_W:1];
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    y_next     = div_rsp.quotient;
                    state_next = ST_TEST;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_DATA_W - ROW_W - 2*COL_W - COLOR_W){1'b0}},
                                    color_reg, span.x_end, span.x_start, span.row};
                    m_user_next  = span.visible;
                    m_last_next  = row_last;
                    if (row_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        dy_next    = dy_reg + 1'b1;
                        state_next = ST_ROW;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        color_reg  <= color_next;
        top_reg    <= top_next;
        r_reg      <= r_next;
        r2_reg     <= r2_next;
        dy_reg     <= dy_next;
        n_reg      <= n_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

### hdl/csg_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module csg_chk
    import csg_pkg::*;
#(
    parameter int SCREEN_WIDTH = 320
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic                m_tuser,
    input wire logic                m_tlast
);

    localparam logic COLS_FIT = SCREEN_WIDTH <= (1 << COL_W);

    // a stalled span holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled span changed");

    // hidden spans carry zero columns
    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[ROW_W +: 2*COL_W] == '0)
        else $error("hidden span with nonzero columns");

    // visible spans are ordered
    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && COLS_FIT |->
            m_tdata[ROW_W +: COL_W] <= m_tdata[ROW_W + COL_W +: COL_W])
        else $error("span start past span end");

    // the block is not ready again right after it takes a command
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after a request");

endmodule

bind filled_circle_span_generator csg_chk #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
) u_csg_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
